// ----- src/slru_pkg.sv -----
package slru_pkg;

   localparam int NUM_SETS = 4;
   localparam int WAYS     = 4;
   localparam int ENTRIES  = NUM_SETS * WAYS;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CNT_W   = $clog2(WAYS + 1);
   localparam int RANK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int OLD_W   = RANK_W + 1;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_GET    = 2'd1,
      KIND_UPDATE = 2'd2
   } kind_type;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_PROMOTE,
      S_COMMIT,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic               entry_valid;
      logic [KEY_W-1:0]   entry_key;
      logic [RANK_W-1:0]  entry_rank;
      logic               is_target;
      logic [OLD_W-1:0]   old_rank;
      logic [KEY_W-1:0]   req_key;
      logic [RANK_W-1:0]  best_rank;
   } unit_in_type;

   typedef struct packed {
      logic               match;
      logic               free;
      logic               better;
      logic               rank_we;
      logic [RANK_W-1:0]  rank_next;
   } unit_out_type;

endpackage

// ----- src/slru_way_unit.sv -----
module slru_way_unit
   import slru_pkg::*;
(
   input  unit_in_type  unit_in,
   output unit_out_type unit_out
);

   always_comb begin
      unit_out.match  = unit_in.entry_valid && (unit_in.entry_key == unit_in.req_key);
      unit_out.free   = !unit_in.entry_valid;
      unit_out.better = unit_in.entry_rank > unit_in.best_rank;
      if (unit_in.is_target) begin
         unit_out.rank_we   = 1'b1;
         unit_out.rank_next = '0;
      end else if (unit_in.entry_valid && ({1'b0, unit_in.entry_rank} < unit_in.old_rank)) begin
         unit_out.rank_we   = 1'b1;
         unit_out.rank_next = unit_in.entry_rank + RANK_W'(1);
      end else begin
         unit_out.rank_we   = 1'b0;
         unit_out.rank_next = unit_in.entry_rank;
      end
   end

endmodule

// ----- src/set_assoc_lru_cache_unit.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_kind, req_key, req_write_value
// rsp      out        rsp_valid / rsp_ready  rsp_hit, rsp_read_value
//
// A request walks the ways of its set through one compare unit and one read
// port per store: once to look up and, for inserts and hits, once more to
// rewrite ranks. An unused kind goes straight to respond. Reset is synchronous
// and clears the state, rsp_valid and the valid bits. A new request is taken
// while the previous result still waits on rsp; the respond step holds until
// that result is accepted.
module set_assoc_lru_cache_unit
   import slru_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic [KEY_W-1:0]          req_key,
   input  logic signed [VALUE_W-1:0] req_write_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_hit,
   output logic signed [VALUE_W-1:0] rsp_read_value
);

   function automatic logic [ADDR_W-1:0] entry_addr(logic [SET_W-1:0] s, logic [WAY_W-1:0] w);
      return ADDR_W'(int'(s) * WAYS + int'(w));
   endfunction

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [1:0]                 kind_ff, kind_in;
   logic [KEY_W-1:0]           key_ff, key_in;
   logic signed [VALUE_W-1:0]  wval_ff, wval_in;
   logic [SET_W-1:0]           set_ff, set_in;
   logic                       found_ff, found_in;
   logic [WAY_W-1:0]           found_way_ff, found_way_in;
   logic [RANK_W-1:0]          found_rank_ff, found_rank_in;
   logic signed [VALUE_W-1:0]  found_value_ff, found_value_in;
   logic                       free_ff, free_in;
   logic [WAY_W-1:0]           free_way_ff, free_way_in;
   logic [RANK_W-1:0]          best_rank_ff, best_rank_in;
   logic [WAY_W-1:0]           best_way_ff, best_way_in;
   logic [WAY_W-1:0]           tgt_way_ff, tgt_way_in;
   logic [OLD_W-1:0]           old_rank_ff, old_rank_in;
   logic [ENTRIES-1:0]         valid_ff, valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_hit_ff, rsp_hit_in;
   logic signed [VALUE_W-1:0]  rsp_read_value_ff, rsp_read_value_in;

   logic [KEY_W-1:0]           key_mem_ff [ENTRIES];
   logic signed [VALUE_W-1:0]  value_mem_ff [ENTRIES];
   logic [RANK_W-1:0]          rank_mem_ff [ENTRIES];
   logic [KEY_W-1:0]           rd_key_ff;
   logic signed [VALUE_W-1:0]  rd_value_ff;
   logic [RANK_W-1:0]          rd_rank_ff;

   logic [WAY_W-1:0]           rd_way;
   logic [WAY_W-1:0]           cur_way;
   logic [ADDR_W-1:0]          rd_addr;
   logic [ADDR_W-1:0]          cur_addr;
   logic [ADDR_W-1:0]          kv_waddr;
   logic                       kv_we;
   logic                       rank_we;
   unit_in_type                unit_in;
   unit_out_type               unit_out;

   assign rd_way   = (int'(cnt_ff) < WAYS) ? WAY_W'(cnt_ff) : '0;
   assign cur_way  = WAY_W'(cnt_ff - CNT_W'(1));
   assign rd_addr  = entry_addr(set_ff, rd_way);
   assign cur_addr = entry_addr(set_ff, cur_way);
   assign kv_waddr = entry_addr(set_ff, tgt_way_ff);

   always_comb begin
      unit_in.entry_valid = valid_ff[cur_addr];
      unit_in.entry_key   = rd_key_ff;
      unit_in.entry_rank  = rd_rank_ff;
      unit_in.is_target   = (cur_way == tgt_way_ff);
      unit_in.old_rank    = old_rank_ff;
      unit_in.req_key     = key_ff;
      unit_in.best_rank   = best_rank_ff;
   end

   slru_way_unit u_way_unit (
      .unit_in  (unit_in),
      .unit_out (unit_out)
   );

   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      kind_in           = kind_ff;
      key_in            = key_ff;
      wval_in           = wval_ff;
      set_in            = set_ff;
      found_in          = found_ff;
      found_way_in      = found_way_ff;
      found_rank_in     = found_rank_ff;
      found_value_in    = found_value_ff;
      free_in           = free_ff;
      free_way_in       = free_way_ff;
      best_rank_in      = best_rank_ff;
      best_way_in       = best_way_ff;
      tgt_way_in        = tgt_way_ff;
      old_rank_in       = old_rank_ff;
      valid_in          = valid_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_hit_in        = rsp_hit_ff;
      rsp_read_value_in = rsp_read_value_ff;
      kv_we             = 1'b0;
      rank_we           = 1'b0;
      req_ready         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in      = req_kind;
               key_in       = req_key;
               wval_in      = req_write_value;
               set_in       = SET_W'(req_key % NUM_SETS);
               cnt_in       = '0;
               found_in     = 1'b0;
               free_in      = 1'b0;
               best_rank_in = '0;
               best_way_in  = '0;
               if (req_kind inside {KIND_INSERT, KIND_GET, KIND_UPDATE}) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_RESPOND;
               end
            end
         end
         S_SCAN: begin
            if (cnt_ff != '0) begin
               if (unit_out.match && !found_ff) begin
                  found_in       = 1'b1;
                  found_way_in   = cur_way;
                  found_rank_in  = rd_rank_ff;
                  found_value_in = rd_value_ff;
               end
               if (unit_out.free && !free_ff) begin
                  free_in     = 1'b1;
                  free_way_in = cur_way;
               end
               if (unit_out.better) begin
                  best_rank_in = rd_rank_ff;
                  best_way_in  = cur_way;
               end
            end
            if (int'(cnt_ff) == WAYS) begin
               state_in = S_DECIDE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_DECIDE: begin
            cnt_in = '0;
            if (kind_ff == KIND_INSERT) begin
               state_in = S_PROMOTE;
               if (found_ff) begin
                  tgt_way_in  = found_way_ff;
                  old_rank_in = {1'b0, found_rank_ff};
               end else if (free_ff) begin
                  tgt_way_in  = free_way_ff;
                  old_rank_in = OLD_W'(WAYS);
               end else begin
                  tgt_way_in  = best_way_ff;
                  old_rank_in = {1'b0, best_rank_ff};
               end
            end else if (found_ff) begin
               state_in    = S_PROMOTE;
               tgt_way_in  = found_way_ff;
               old_rank_in = {1'b0, found_rank_ff};
            end else begin
               state_in = S_RESPOND;
            end
         end
         S_PROMOTE: begin
            if (cnt_ff != '0) begin
               rank_we = unit_out.rank_we;
            end
            if (int'(cnt_ff) == WAYS) begin
               state_in = S_COMMIT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_COMMIT: begin
            kv_we = kind_ff inside {KIND_INSERT, KIND_UPDATE};
            if (kind_ff == KIND_INSERT) begin
               valid_in[kv_waddr] = 1'b1;
            end
            state_in = S_RESPOND;
         end
         S_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_hit_in        = found_ff;
               rsp_read_value_in = (kind_ff == KIND_GET && found_ff) ? found_value_ff : '0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff            <= cnt_in;
      kind_ff           <= kind_in;
      key_ff            <= key_in;
      wval_ff           <= wval_in;
      set_ff            <= set_in;
      found_ff          <= found_in;
      found_way_ff      <= found_way_in;
      found_rank_ff     <= found_rank_in;
      found_value_ff    <= found_value_in;
      free_ff           <= free_in;
      free_way_ff       <= free_way_in;
      best_rank_ff      <= best_rank_in;
      best_way_ff       <= best_way_in;
      tgt_way_ff        <= tgt_way_in;
      old_rank_ff       <= old_rank_in;
      rsp_hit_ff        <= rsp_hit_in;
      rsp_read_value_ff <= rsp_read_value_in;
   end

   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem_ff[rd_addr];
      rd_value_ff <= value_mem_ff[rd_addr];
      rd_rank_ff  <= rank_mem_ff[rd_addr];
      if (kv_we) begin
         key_mem_ff[kv_waddr]   <= key_ff;
         value_mem_ff[kv_waddr] <= wval_ff;
      end
      if (rank_we) begin
         rank_mem_ff[cur_addr] <= unit_out.rank_next;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;

   a_rsp_from_respond: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESPOND))
      else $error("result raised outside the respond step");

   a_insert_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT && kind_ff == KIND_INSERT) |=> valid_ff[$past(kv_waddr)])
      else $error("inserted entry not marked valid");

   a_found_is_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && found_ff) |-> valid_ff[entry_addr(set_ff, found_way_ff)])
      else $error("hit recorded on an invalid way");

endmodule
